@@ hdl/rectangle_subtract_clip_core_defines.svh @@
// Assertion macros shared by the rectangle subtract clip RTL.
`ifndef RECTANGLE_SUBTRACT_CLIP_CORE_DEFINES_SVH
`define RECTANGLE_SUBTRACT_CLIP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RSC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/rsc_pkg.sv @@
// Types, constants and codes for the rectangle subtract clip block.
`default_nettype none

package rsc_pkg;

  localparam int COORD_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_BANDS = 4;
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  typedef logic signed [COORD_W-1:0] coord_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_RIGHT  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_BOTTOM = 2'd3;

  // Band positions within the band mask, in emission order
  localparam int BAND_TOP    = 0;
  localparam int BAND_BOTTOM = 1;
  localparam int BAND_LEFT   = 2;
  localparam int BAND_RIGHT  = 3;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_EMPTY,
    KIND_BANDS
  } kind_e;

  typedef struct packed {
    coord_t left;
    coord_t top;
    coord_t right;
    coord_t bottom;
  } rect_t;

  typedef struct packed {
    coord_t src_left;
    coord_t src_top;
    coord_t src_right;
    coord_t src_bottom;
  } src_t;

  typedef struct packed {
    coord_t out_left;
    coord_t out_top;
    coord_t out_right;
    coord_t out_bottom;
    logic   is_empty;
    logic   last_piece;
  } res_t;

  typedef struct packed {
    src_t                 src;
    rect_t                isect;
    kind_e                kind;
    logic [NUM_BANDS-1:0] bands;
  } job_t;

endpackage

`default_nettype wire

@@ hdl/rectangle_subtract_clip_core.sv @@
// Top level of the rectangle subtract clip block: clip registers and datapath.
//
//  channel   | signals                                | handshake
//  ----------+----------------------------------------+------------------------------
//  request   | start, busy, src_i                     | taken when start && !busy
//  result    | res_valid_o, res_o                     | one-cycle strobe, no stall
//  config    | cfg_we_i, cfg_idx_i, cfg_wdata_i       | written when cfg_we_i is high
//
// Each request yields one to four pieces; the emitter puts out one piece per
// clock. At the earliest, the first piece reaches the result ports through
// the queue write at the accepting edge, the job load and the output register.
// busy is high while the four-entry job queue is full. Reset is asynchronous,
// clears the clip registers to zero and empties the queue.
`default_nettype none

module rectangle_subtract_clip_core (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             start,
  output logic                            busy,
  input  rsc_pkg::src_t                   src_i,
  input  wire                             cfg_we_i,
  input  wire [rsc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [rsc_pkg::COORD_W-1:0]      cfg_wdata_i,
  output logic                            res_valid_o,
  output rsc_pkg::res_t                   res_o
);

  rsc_pkg::rect_t clip_q;
  logic           push;
  rsc_pkg::job_t  push_job;
  logic           q_full;
  logic           q_valid;
  rsc_pkg::job_t  q_head;
  logic           q_pop;

  // Write clip registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        rsc_pkg::CFG_CLIP_LEFT:   clip_q.left   <= cfg_wdata_i;
        rsc_pkg::CFG_CLIP_TOP:    clip_q.top    <= cfg_wdata_i;
        rsc_pkg::CFG_CLIP_RIGHT:  clip_q.right  <= cfg_wdata_i;
        rsc_pkg::CFG_CLIP_BOTTOM: clip_q.bottom <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign busy = q_full;

  rsc_front u_front (
    .start_i (start),
    .full_i  (q_full),
    .src_i   (src_i),
    .clip_i  (clip_q),
    .push_o  (push),
    .job_o   (push_job)
  );

  rsc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (q_head)
  );

  rsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .head_i      (q_head),
    .pop_o       (q_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

@@ hdl/rsc_front.sv @@
// Front end: intersects a request with the clip window and classifies it.
`default_nettype none

module rsc_front (
  input  wire                  start_i,
  input  wire                  full_i,
  input  rsc_pkg::src_t        src_i,
  input  rsc_pkg::rect_t       clip_i,
  output logic                 push_o,
  output rsc_pkg::job_t        job_o
);

  rsc_pkg::rect_t isect;
  logic           disjoint;
  logic           covered;

  // Accept a request whenever the queue has room
  assign push_o = start_i && !full_i;

  // Intersect source and clip edge by edge
  always_comb begin
    isect.left   = (src_i.src_left   > clip_i.left)   ? src_i.src_left   : clip_i.left;
    isect.top    = (src_i.src_top    > clip_i.top)    ? src_i.src_top    : clip_i.top;
    isect.right  = (src_i.src_right  < clip_i.right)  ? src_i.src_right  : clip_i.right;
    isect.bottom = (src_i.src_bottom < clip_i.bottom) ? src_i.src_bottom : clip_i.bottom;
  end

  // Classify: no overlap, fully covered, or a set of bands to emit
  always_comb begin
    disjoint = (isect.left > isect.right) || (isect.top > isect.bottom);
    covered  = (src_i.src_left >= isect.left) && (src_i.src_right <= isect.right) &&
               (src_i.src_top >= isect.top) && (src_i.src_bottom <= isect.bottom);

    job_o.src   = src_i;
    job_o.isect = isect;
    job_o.bands[rsc_pkg::BAND_TOP]    = src_i.src_top < isect.top;
    job_o.bands[rsc_pkg::BAND_BOTTOM] = isect.bottom < src_i.src_bottom;
    job_o.bands[rsc_pkg::BAND_LEFT]   = src_i.src_left < isect.left;
    job_o.bands[rsc_pkg::BAND_RIGHT]  = isect.right < src_i.src_right;

    if (disjoint) begin
      job_o.kind = rsc_pkg::KIND_PASS;
    end else if (covered) begin
      job_o.kind = rsc_pkg::KIND_EMPTY;
    end else begin
      job_o.kind = rsc_pkg::KIND_BANDS;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rsc_queue.sv @@
// Small job queue between the classifying front end and the piece emitter.
`default_nettype none

`include "rectangle_subtract_clip_core_defines.svh"

module rsc_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  rsc_pkg::job_t        job_i,
  input  wire                  pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output rsc_pkg::job_t        head_o
);

  rsc_pkg::job_t                  mem_q [rsc_pkg::QDEPTH];
  logic [rsc_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [rsc_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [rsc_pkg::QCNT_W-1:0]     cnt_q, cnt_d;

  assign full_o  = (cnt_q == rsc_pkg::QCNT_W'(rsc_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap and track the fill level
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == rsc_pkg::QPTR_W'(rsc_pkg::QDEPTH - 1)) ? '0
                 : wr_ptr_q + rsc_pkg::QPTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == rsc_pkg::QPTR_W'(rsc_pkg::QDEPTH - 1)) ? '0
                 : rd_ptr_q + rsc_pkg::QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + rsc_pkg::QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - rsc_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  `RSC_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, full_o, !push_i, "push into full queue")
  `RSC_ASSERT_NXT(a_fill_tracks, clk_i, rst_ni, push_i && !pop_i,
                  cnt_q == $past(cnt_q) + 1, "fill level lost a push")

endmodule

`default_nettype wire

@@ hdl/rsc_back.sv @@
// Back end: walks each job's bands and emits one registered piece per cycle.
`default_nettype none

`include "rectangle_subtract_clip_core_defines.svh"

module rsc_back (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  q_valid_i,
  input  rsc_pkg::job_t        head_i,
  output logic                 pop_o,
  output logic                 res_valid_o,
  output rsc_pkg::res_t        res_o
);

  logic                            act_q, act_d;
  rsc_pkg::job_t                   job_q;
  logic [rsc_pkg::NUM_BANDS-1:0]   mask_q, mask_d;
  logic [rsc_pkg::NUM_BANDS-1:0]   pick;
  logic [rsc_pkg::NUM_BANDS-1:0]   rest;
  rsc_pkg::res_t                   piece;
  logic                            done;
  logic                            res_valid_q;
  rsc_pkg::res_t                   res_q;

  // Build the piece for the current job and its lowest pending band
  always_comb begin
    pick  = mask_q & (~mask_q + rsc_pkg::NUM_BANDS'(1));
    rest  = mask_q & ~pick;
    piece = '0;
    case (job_q.kind)
      rsc_pkg::KIND_PASS: begin
        piece.out_left   = job_q.src.src_left;
        piece.out_top    = job_q.src.src_top;
        piece.out_right  = job_q.src.src_right;
        piece.out_bottom = job_q.src.src_bottom;
        piece.last_piece = 1'b1;
      end
      rsc_pkg::KIND_EMPTY: begin
        piece.is_empty   = 1'b1;
        piece.last_piece = 1'b1;
      end
      rsc_pkg::KIND_BANDS: begin
        piece.last_piece = (rest == '0);
        if (pick[rsc_pkg::BAND_TOP]) begin
          piece.out_left   = job_q.src.src_left;
          piece.out_top    = job_q.src.src_top;
          piece.out_right  = job_q.src.src_right;
          piece.out_bottom = job_q.isect.top - rsc_pkg::coord_t'(1);
        end else if (pick[rsc_pkg::BAND_BOTTOM]) begin
          piece.out_left   = job_q.src.src_left;
          piece.out_top    = job_q.isect.bottom + rsc_pkg::coord_t'(1);
          piece.out_right  = job_q.src.src_right;
          piece.out_bottom = job_q.src.src_bottom;
        end else if (pick[rsc_pkg::BAND_LEFT]) begin
          piece.out_left   = job_q.src.src_left;
          piece.out_top    = job_q.isect.top;
          piece.out_right  = job_q.isect.left - rsc_pkg::coord_t'(1);
          piece.out_bottom = job_q.isect.bottom;
        end else begin
          piece.out_left   = job_q.isect.right + rsc_pkg::coord_t'(1);
          piece.out_top    = job_q.isect.top;
          piece.out_right  = job_q.src.src_right;
          piece.out_bottom = job_q.isect.bottom;
        end
      end
      default: begin
        piece.last_piece = 1'b1;
      end
    endcase
  end

  // Load the next job when idle or when this job's last piece goes out
  always_comb begin
    done  = !act_q || piece.last_piece;
    pop_o = q_valid_i && done;
    if (pop_o) begin
      act_d  = 1'b1;
      mask_d = head_i.bands;
    end else begin
      act_d  = !done;
      mask_d = rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      act_q       <= act_d;
      res_valid_q <= act_q;
    end
  end

  // Hold job payload and output register
  always_ff @(posedge clk_i) begin
    mask_q <= mask_d;
    if (pop_o) begin
      job_q <= head_i;
    end
    if (act_q) begin
      res_q <= piece;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `RSC_ASSERT_IMP(a_bands_pending, clk_i, rst_ni,
                  act_q && (job_q.kind == rsc_pkg::KIND_BANDS), mask_q != '0,
                  "band job active with no band left")
  `RSC_ASSERT_NXT(a_one_band_per_cycle, clk_i, rst_ni, act_q && !piece.last_piece,
                  act_q && ($countones(mask_q) + 1 == $countones($past(mask_q))),
                  "band walk did not retire exactly one band")
  `RSC_ASSERT_IMP(a_more_pieces_follow, clk_i, rst_ni,
                  res_valid_q && !res_q.last_piece, act_q,
                  "request ended without a last piece")

endmodule

`default_nettype wire
